@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the BMP stream decoder; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BMPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmpd: same-cycle check failed");

// next-cycle implication
`define BMPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmpd: next-cycle check failed");

`else

`define BMPD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BMPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/bmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared constants, status codes and structs of the BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // dimension registers hold up to 32767, row byte counts up to 4 * 32767
  localparam int DIM_W  = 15;
  localparam int ROWB_W = DIM_W + 2;

  localparam int RES_DEPTH = 4;

  localparam logic [15:0] SIG_WORD       = 16'h4D42;
  localparam logic [31:0] MIN_DIB        = 32'd40;
  localparam logic [31:0] FILE_HDR_BYTES = 32'h0E;
  localparam logic [31:0] OFS_POS        = 32'h0A;
  localparam logic [31:0] DIB_POS        = 32'h0E;
  localparam logic [31:0] DIM_POS        = 32'h12;
  localparam logic [31:0] HDR_END        = 32'd34;

  // byte positions at which a header field completes
  localparam logic [31:0] POS_SIG    = 32'd1;
  localparam logic [31:0] POS_OFS    = OFS_POS + 32'd3;
  localparam logic [31:0] POS_DIB    = DIB_POS + 32'd3;
  localparam logic [31:0] POS_WIDTH  = DIM_POS + 32'd3;
  localparam logic [31:0] POS_HEIGHT = DIM_POS + 32'd7;
  localparam logic [31:0] POS_PLANES = DIM_POS + 32'd9;
  localparam logic [31:0] POS_BPP    = DIM_POS + 32'd11;
  localparam logic [31:0] POS_COMP   = HDR_END - 32'd1;

  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SIG_SHORT    = 4'd1,
    ST_BAD_SIG      = 4'd2,
    ST_OFS_SHORT    = 4'd3,
    ST_DIB_SHORT    = 4'd4,
    ST_DIB_SMALL    = 4'd5,
    ST_HDR_SHORT    = 4'd6,
    ST_BAD_DIMS     = 4'd7,
    ST_BAD_PLANES   = 4'd8,
    ST_BAD_BPP      = 4'd9,
    ST_BAD_COMP     = 4'd10,
    ST_TOO_LARGE    = 4'd11,
    ST_OFS_OVERLAP  = 4'd12,
    ST_PIXELS_SHORT = 4'd13
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  pixel_blue;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_alpha;
    logic [3:0]  status_code;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        final_flag;
  } res_t;

  // decoded header as seen by the pixel path
  typedef struct packed {
    logic              header_valid;
    logic              in_data;
    logic              top_first;
    logic              has_alpha;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [ROWB_W-1:0] data_bytes;
    logic [ROWB_W-1:0] stride;
  } hdr_t;

  // header outcome after the current item
  typedef struct packed {
    status_t code;
    logic    valid_hdr;
  } hfin_t;

  // pixel path result for the current item
  typedef struct packed {
    logic valid;
    logic rows_short;
    res_t res;
  } pix_out_t;

endpackage

@@ rtl/bmpd_byte_if.sv @@
// ----------------------------------------------------------------------------
// bmpd_byte_if
// File byte channel: one byte per item, with an end-of-file mark.
// ----------------------------------------------------------------------------
interface bmpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

@@ rtl/bmpd_result_if.sv @@
// ----------------------------------------------------------------------------
// bmpd_result_if
// Result channel: a pixel or the final status of a file per item.
// ----------------------------------------------------------------------------
interface bmpd_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  pixel_blue;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_alpha;
  logic [3:0]  status_code;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        final_flag;

  modport source (output valid, input ready, output kind, output pixel_x, output pixel_y,
                  output pixel_blue, output pixel_green, output pixel_red,
                  output pixel_alpha, output status_code, output image_width,
                  output image_height, output final_flag);
  modport sink   (input valid, output ready, input kind, input pixel_x, input pixel_y,
                  input pixel_blue, input pixel_green, input pixel_red,
                  input pixel_alpha, input status_code, input image_width,
                  input image_height, input final_flag);
endinterface

@@ rtl/bmpd_result_fifo.sv @@
// ----------------------------------------------------------------------------
// bmpd_result_fifo
// Small result queue: takes up to two items a cycle, hands out one.
// ----------------------------------------------------------------------------
module bmpd_result_fifo import bmpd_pkg::*; #(
  parameter int DEPTH = RES_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_first,
  input  res_t first,
  input  logic push_second,
  input  res_t second,
  output logic room,
  output logic head_valid,
  output res_t head,
  input  logic pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] wr_alt;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] rd_ptr_inc;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  always_comb begin
    wr_alt      = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
    rd_ptr_inc  = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
    wr_ptr_next = wr_ptr;
    if (push_second) begin
      wr_ptr_next = (wr_alt == PW'(DEPTH - 1)) ? '0 : wr_alt + PW'(1);
    end else if (push_first) begin
      wr_ptr_next = wr_alt;
    end
    count_next = count + CW'(push_first) + CW'(push_second) - CW'(pop);
  end

  assign room       = (count <= CW'(DEPTH - 2));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_first) begin
      mem[wr_ptr] <= first;
    end
    if (push_second) begin
      mem[wr_alt] <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr_inc;
      end
    end
  end

endmodule

@@ rtl/bmpd_header.sv @@
// ----------------------------------------------------------------------------
// bmpd_header
// Header parser: byte counter, field shift register and in-order checks.
// ----------------------------------------------------------------------------
module bmpd_header import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output hdr_t       hdr,
  output hfin_t      fin
);

  logic [31:0]       byte_position;
  logic [31:0]       byte_position_next;
  logic [31:0]       field_shift;
  logic [31:0]       field_shift_next;
  logic [31:0]       data_offset;
  logic [31:0]       data_offset_next;
  logic [DIM_W-1:0]  stored_width;
  logic [DIM_W-1:0]  stored_width_next;
  logic [DIM_W-1:0]  stored_height;
  logic [DIM_W-1:0]  stored_height_next;
  logic              rows_top_first;
  logic              rows_top_first_next;
  logic              has_alpha;
  logic              has_alpha_next;
  logic              header_valid;
  logic              header_valid_next;
  status_t           error_state;
  status_t           error_state_next;
  logic [ROWB_W-1:0] data_bytes;
  logic [ROWB_W-1:0] data_bytes_next;
  logic [ROWB_W-1:0] stride;
  logic [ROWB_W-1:0] stride_next;

  logic [31:0]       v;
  logic [31:0]       mag;
  logic              active;
  logic [ROWB_W-1:0] db_calc;
  logic [ROWB_W:0]   stride_calc;

  always_comb begin
    byte_position_next = (byte_position == '1) ? byte_position : byte_position + 32'd1;
    v       = {data_byte, field_shift[31:8]};
    mag     = v[31] ? (32'd0 - v) : v;
    active  = (error_state == ST_OK) && !header_valid && (byte_position < HDR_END);
    db_calc = has_alpha ? {stored_width, 2'b00}
                        : ({1'b0, stored_width, 1'b0} + {2'b00, stored_width});
    // round up to a whole number of 32-bit words
    stride_calc = ({1'b0, db_calc} + (ROWB_W + 1)'(3)) & ~((ROWB_W + 1)'(3));

    field_shift_next    = field_shift;
    data_offset_next    = data_offset;
    stored_width_next   = stored_width;
    stored_height_next  = stored_height;
    rows_top_first_next = rows_top_first;
    has_alpha_next      = has_alpha;
    header_valid_next   = header_valid;
    error_state_next    = error_state;
    data_bytes_next     = data_bytes;
    stride_next         = stride;

    if (active) begin
      field_shift_next = v;
      case (byte_position)
        POS_SIG: begin
          if (v[31:16] != SIG_WORD) error_state_next = ST_BAD_SIG;
        end
        POS_OFS: begin
          data_offset_next = v;
        end
        POS_DIB: begin
          if (v < MIN_DIB) begin
            error_state_next = ST_DIB_SMALL;
          end else if ({1'b0, data_offset} < ({1'b0, FILE_HDR_BYTES} + {1'b0, v})) begin
            error_state_next = ST_OFS_OVERLAP;
          end
        end
        POS_WIDTH: begin
          if (v[31] || (v == 32'd0)) begin
            error_state_next = ST_BAD_DIMS;
          end else if (v > 32'(MAX_WIDTH)) begin
            error_state_next = ST_TOO_LARGE;
          end else begin
            stored_width_next = v[DIM_W-1:0];
          end
        end
        POS_HEIGHT: begin
          if (v == 32'd0) begin
            error_state_next = ST_BAD_DIMS;
          end else if (mag > 32'(MAX_HEIGHT)) begin
            error_state_next = ST_TOO_LARGE;
          end else begin
            stored_height_next  = mag[DIM_W-1:0];
            rows_top_first_next = v[31];
          end
        end
        POS_PLANES: begin
          if (v[31:16] != 16'd1) error_state_next = ST_BAD_PLANES;
        end
        POS_BPP: begin
          if ((v[31:16] != BPP_24) && (v[31:16] != BPP_32)) begin
            error_state_next = ST_BAD_BPP;
          end else begin
            has_alpha_next = (v[31:16] == BPP_32);
          end
        end
        POS_COMP: begin
          if (v != 32'd0) begin
            error_state_next = ST_BAD_COMP;
          end else begin
            header_valid_next = 1'b1;
            data_bytes_next   = db_calc;
            stride_next       = stride_calc[ROWB_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    fin.valid_hdr = header_valid_next;
    if (error_state_next != ST_OK) begin
      fin.code = error_state_next;
    end else if (header_valid_next) begin
      fin.code = ST_OK;
    end else if (byte_position_next < 32'd2) begin
      fin.code = ST_SIG_SHORT;
    end else if (byte_position_next < DIB_POS) begin
      fin.code = ST_OFS_SHORT;
    end else if (byte_position_next < DIM_POS) begin
      fin.code = ST_DIB_SHORT;
    end else begin
      fin.code = ST_HDR_SHORT;
    end
  end

  assign hdr.header_valid = header_valid;
  assign hdr.in_data      = (byte_position >= data_offset);
  assign hdr.top_first    = rows_top_first;
  assign hdr.has_alpha    = has_alpha;
  assign hdr.width        = stored_width;
  assign hdr.height       = stored_height;
  assign hdr.data_bytes   = data_bytes;
  assign hdr.stride       = stride;

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_file)) begin
      byte_position  <= '0;
      field_shift    <= '0;
      data_offset    <= '0;
      stored_width   <= '0;
      stored_height  <= '0;
      rows_top_first <= 1'b0;
      has_alpha      <= 1'b0;
      header_valid   <= 1'b0;
      error_state    <= ST_OK;
      data_bytes     <= '0;
      stride         <= '0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      field_shift    <= field_shift_next;
      data_offset    <= data_offset_next;
      stored_width   <= stored_width_next;
      stored_height  <= stored_height_next;
      rows_top_first <= rows_top_first_next;
      has_alpha      <= has_alpha_next;
      header_valid   <= header_valid_next;
      error_state    <= error_state_next;
      data_bytes     <= data_bytes_next;
      stride         <= stride_next;
    end
  end

endmodule

@@ rtl/bmpd_pixel.sv @@
// ----------------------------------------------------------------------------
// bmpd_pixel
// Pixel assembler: gathers BGR(A) bytes, tracks column, row and padding.
// ----------------------------------------------------------------------------
module bmpd_pixel import bmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  input  hdr_t       hdr,
  output pix_out_t   pix
);

  logic [DIM_W-1:0]  column_count;
  logic [DIM_W-1:0]  column_count_next;
  logic [DIM_W-1:0]  row_count;
  logic [DIM_W-1:0]  row_count_next;
  logic [ROWB_W-1:0] row_byte_count;
  logic [ROWB_W-1:0] row_byte_count_next;
  logic [1:0]        pixel_byte_index;
  logic [1:0]        pixel_byte_index_next;
  logic [7:0]        blue;
  logic [7:0]        green;
  logic [7:0]        red;

  logic              active;
  logic              in_row;
  logic              emit;
  logic              row_end;
  logic [1:0]        last_index;
  logic [ROWB_W-1:0] rb_inc;
  logic [DIM_W-1:0]  y;

  always_comb begin
    active     = step && hdr.header_valid && hdr.in_data && (row_count < hdr.height);
    last_index = hdr.has_alpha ? 2'd3 : 2'd2;
    in_row     = (row_byte_count < hdr.data_bytes);
    rb_inc     = row_byte_count + ROWB_W'(1);
    row_end    = (rb_inc >= hdr.stride);
    emit       = active && in_row && (pixel_byte_index == last_index);
    y          = hdr.top_first ? row_count : (hdr.height - DIM_W'(1) - row_count);

    column_count_next     = column_count;
    row_count_next        = row_count;
    row_byte_count_next   = row_byte_count;
    pixel_byte_index_next = pixel_byte_index;
    if (active) begin
      if (in_row) begin
        if (emit) begin
          column_count_next     = column_count + DIM_W'(1);
          pixel_byte_index_next = 2'd0;
        end else begin
          pixel_byte_index_next = pixel_byte_index + 2'd1;
        end
      end
      row_byte_count_next = rb_inc;
      // drop padding and move to the next row
      if (row_end) begin
        row_byte_count_next   = '0;
        column_count_next     = '0;
        pixel_byte_index_next = 2'd0;
        row_count_next        = row_count + DIM_W'(1);
      end
    end

    pix.valid               = emit;
    pix.rows_short          = (row_count_next < hdr.height);
    pix.res.kind            = 1'b0;
    pix.res.pixel_x         = column_count[11:0];
    pix.res.pixel_y         = y[11:0];
    pix.res.pixel_blue      = (pixel_byte_index == 2'd0) ? data_byte : blue;
    pix.res.pixel_green     = (pixel_byte_index == 2'd1) ? data_byte : green;
    pix.res.pixel_red       = (pixel_byte_index == 2'd2) ? data_byte : red;
    pix.res.pixel_alpha     = hdr.has_alpha ? data_byte : 8'hFF;
    pix.res.status_code     = ST_OK;
    pix.res.image_width     = 13'(hdr.width);
    pix.res.image_height    = 13'(hdr.height);
    pix.res.final_flag      = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (active && in_row) begin
      case (pixel_byte_index)
        2'd0:    blue  <= data_byte;
        2'd1:    green <= data_byte;
        2'd2:    red   <= data_byte;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_file)) begin
      column_count     <= '0;
      row_count        <= '0;
      row_byte_count   <= '0;
      pixel_byte_index <= 2'd0;
    end else begin
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      row_byte_count   <= row_byte_count_next;
      pixel_byte_index <= pixel_byte_index_next;
    end
  end

endmodule

@@ rtl/bmp_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// bmp_stream_decoder_core
// Streaming decoder for uncompressed 24 and 32 bit BMP files. Takes one file
// byte per cycle while the result queue has room, with no gaps needed between
// files. The header is checked field by field as it arrives; after the pixel
// offset each complete pixel comes out as BGRA with its column and top-down
// row, padding dropped. The last byte of a file also yields one status item
// with final_flag set, after any pixel that byte completes. Each byte is
// handled in the cycle it is accepted and its results land in a four-entry
// result queue, so a byte is taken every cycle while the queue has room for
// two results; the result side drains one item per cycle while it is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp_stream_decoder_core import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input logic          clk,
  input logic          rst,
  bmpd_byte_if.sink    file_stream,
  bmpd_result_if.source result_stream
);

  hdr_t     hdr;
  hfin_t    fin;
  pix_out_t pix;
  res_t     status_res;
  res_t     first;
  res_t     head;
  logic     step;
  logic     finish;
  logic     room;
  logic     head_valid;

  assign step   = file_stream.valid && file_stream.ready;
  assign finish = step && file_stream.end_of_file;
  assign file_stream.ready = room;

  bmpd_header #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_header (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (file_stream.data_byte),
    .end_of_file (file_stream.end_of_file),
    .hdr         (hdr),
    .fin         (fin)
  );

  bmpd_pixel u_pixel (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (file_stream.data_byte),
    .end_of_file (file_stream.end_of_file),
    .hdr         (hdr),
    .pix         (pix)
  );

  always_comb begin
    status_res              = '0;
    status_res.kind         = 1'b1;
    status_res.final_flag   = 1'b1;
    if (fin.valid_hdr) begin
      status_res.status_code  = pix.rows_short ? ST_PIXELS_SHORT : ST_OK;
      status_res.image_width  = 13'(hdr.width);
      status_res.image_height = 13'(hdr.height);
    end else begin
      status_res.status_code  = fin.code;
    end
    first = pix.valid ? pix.res : status_res;
  end

  bmpd_result_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_first  (pix.valid || finish),
    .first       (first),
    .push_second (pix.valid && finish),
    .second      (status_res),
    .room        (room),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (head_valid && result_stream.ready)
  );

  assign result_stream.valid        = head_valid;
  assign result_stream.kind         = head.kind;
  assign result_stream.pixel_x      = head.pixel_x;
  assign result_stream.pixel_y      = head.pixel_y;
  assign result_stream.pixel_blue   = head.pixel_blue;
  assign result_stream.pixel_green  = head.pixel_green;
  assign result_stream.pixel_red    = head.pixel_red;
  assign result_stream.pixel_alpha  = head.pixel_alpha;
  assign result_stream.status_code  = head.status_code;
  assign result_stream.image_width  = head.image_width;
  assign result_stream.image_height = head.image_height;
  assign result_stream.final_flag   = head.final_flag;

  `BMPD_ASSERT_NEXT(a_state_clear_after_eof, clk, rst, finish, !hdr.header_valid)
  `BMPD_ASSERT_IMPL(a_pixel_needs_header, clk, rst, pix.valid, step && hdr.header_valid)
  `BMPD_ASSERT_IMPL(a_final_only_on_status, clk, rst, head_valid, head.final_flag == head.kind)

endmodule
